/* rtl/core/lsmb_pkg.sv */
// ----------------------------------------------------------------------------
// lsmb_pkg
// Shared types and constants for the lidar sector minimum binning block.
// ----------------------------------------------------------------------------
package lsmb_pkg;

  // Sector layout: the turn is split evenly into SECTORS bins.
  localparam int SECTORS = 8;
  localparam int SEC_W   = $clog2(SECTORS);

  // Sample queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [15:0] NO_RETURN = 16'hFFFF;
  localparam logic [15:0] HALF_TURN = 16'h8000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE   = 3'd3;

  // Register values after reset.
  localparam logic [15:0] RST_START_ANGLE = 16'h8000;
  localparam logic [15:0] RST_ANGLE_STEP  = 16'd182;
  localparam logic [15:0] RST_MIN_RANGE   = 16'd100;
  localparam logic [15:0] RST_MAX_RANGE   = 16'd30000;

  // Configuration as seen by the front part.
  typedef struct packed {
    logic [15:0] start_angle;
    logic [15:0] angle_step;
    logic [15:0] min_range_mm;
    logic [15:0] max_range_mm;
  } cfg_t;

  // One classified sample on its way to the back part.
  typedef struct packed {
    logic [15:0]      range_mm;
    logic [SEC_W-1:0] sector;
    logic             keep;
    logic             last;
  } entry_t;

endpackage

/* rtl/core/lidar_sector_min_binning.sv */
// ----------------------------------------------------------------------------
// lidar_sector_min_binning
// Bins lidar range samples into angular sectors and reports sector minima.
// ----------------------------------------------------------------------------
// Usage: samples enter through push/full, one item per cycle while full is
// low. Each item gets a beam angle that starts at start_angle and advances by
// angle_step. Items that are not finite or fall outside the range window are
// dropped; the rest lower the minimum of their sector.
// The item flagged end_of_scan closes the scan: the back part then scans
// every sector for the best one and then places one result item per sector
// in the output register, sector 0 first, last_of_run on the final one.
// Samples stream at one per cycle while full is low; the four-entry sample
// queue keeps accepting during a drain, and full rises once it fills.
// If the receiver holds pop low, the output register holds its item and the
// drain waits; new samples still fill the queue.
// Configuration writes are always accepted (cfg_ready is always high).
// Reset loads the register defaults, clears all minima to 65535 and empties
// the sample queue and the output register.
// ----------------------------------------------------------------------------
module lidar_sector_min_binning (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [15:0]                    range_mm,
  input  logic                           not_finite,
  input  logic                           end_of_scan,
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     sector_index,
  output logic [15:0]                    sector_min_mm,
  output logic [2:0]                     open_sector,
  output logic signed [2:0]              steer_eighths_pi,
  output logic                           last_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import lsmb_pkg::*;

  cfg_t   cfg;
  entry_t front_entry;
  entry_t back_entry;
  logic   take;
  logic   q_full;
  logic   q_empty;
  logic   q_rd;
  logic   cfg_wr;
  logic   load_start;

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign load_start = cfg_wr && (cfg_index == REG_START_ANGLE);
  assign full       = q_full;
  assign take       = push && !q_full;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_angle  <= RST_START_ANGLE;
      cfg.angle_step   <= RST_ANGLE_STEP;
      cfg.min_range_mm <= RST_MIN_RANGE;
      cfg.max_range_mm <= RST_MAX_RANGE;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_START_ANGLE: cfg.start_angle  <= cfg_data;
        REG_ANGLE_STEP:  cfg.angle_step   <= cfg_data;
        REG_MIN_RANGE:   cfg.min_range_mm <= cfg_data;
        REG_MAX_RANGE:   cfg.max_range_mm <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lsmb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .load_start  (load_start),
    .load_value  (cfg_data),
    .take        (take),
    .range_mm    (range_mm),
    .not_finite  (not_finite),
    .end_of_scan (end_of_scan),
    .entry       (front_entry)
  );

  lsmb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (take),
    .wr_data (front_entry),
    .rd      (q_rd),
    .rd_data (back_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  lsmb_back u_back (
    .clk              (clk),
    .rst              (rst),
    .entry            (back_entry),
    .q_empty          (q_empty),
    .q_rd             (q_rd),
    .pop              (pop),
    .empty            (empty),
    .sector_index     (sector_index),
    .sector_min_mm    (sector_min_mm),
    .open_sector      (open_sector),
    .steer_eighths_pi (steer_eighths_pi),
    .last_of_run      (last_of_run)
  );

endmodule

/* rtl/core/lsmb_front.sv */
// ----------------------------------------------------------------------------
// lsmb_front
// Accepts samples, tracks the beam angle and classifies each sample into a
// sector with a keep flag for the range gate.
// ----------------------------------------------------------------------------
module lsmb_front (
  input  logic              clk,
  input  logic              rst,
  input  lsmb_pkg::cfg_t    cfg,
  input  logic              load_start,
  input  logic [15:0]       load_value,
  input  logic              take,
  input  logic [15:0]       range_mm,
  input  logic              not_finite,
  input  logic              end_of_scan,
  output lsmb_pkg::entry_t  entry
);
  import lsmb_pkg::*;

  logic [15:0] beam_angle;
  logic [15:0] shifted;
  logic [31:0] prod;

  // Sector is the angle plus a half turn, scaled to the sector count.
  assign shifted = beam_angle + HALF_TURN;
  assign prod    = 32'(shifted) * 32'(SECTORS);

  always_comb begin
    entry.range_mm = range_mm;
    entry.sector   = prod[16 +: SEC_W];
    entry.keep     = !not_finite && (range_mm >= cfg.min_range_mm) &&
                     (range_mm <= cfg.max_range_mm);
    entry.last     = end_of_scan;
  end

  // The angle advances per item, restarts after the last item of a scan and is loaded by a start angle write.
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle <= RST_START_ANGLE;
    end else if (load_start) begin
      beam_angle <= load_value;
    end else if (take) begin
      if (end_of_scan) begin
        beam_angle <= cfg.start_angle;
      end else begin
        beam_angle <= beam_angle + cfg.angle_step;
      end
    end
  end

endmodule

/* rtl/core/lsmb_queue.sv */
// ----------------------------------------------------------------------------
// lsmb_queue
// Short first-in first-out queue of classified samples between the front and
// back parts.
// ----------------------------------------------------------------------------
module lsmb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  lsmb_pkg::entry_t  wr_data,
  input  logic              rd,
  output lsmb_pkg::entry_t  rd_data,
  output logic              full,
  output logic              empty
);
  import lsmb_pkg::*;

  entry_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/lsmb_back.sv */
// ----------------------------------------------------------------------------
// lsmb_back
// Applies classified samples to the sector minima and, at the end of a scan,
// finds the best sector and drains one item per sector into the output.
// ----------------------------------------------------------------------------
module lsmb_back (
  input  logic              clk,
  input  logic              rst,
  input  lsmb_pkg::entry_t  entry,
  input  logic              q_empty,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output logic [2:0]        sector_index,
  output logic [15:0]       sector_min_mm,
  output logic [2:0]        open_sector,
  output logic signed [2:0] steer_eighths_pi,
  output logic              last_of_run
);
  import lsmb_pkg::*;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [15:0]      minima [SECTORS];
  logic [SEC_W-1:0] cnt;
  logic [SEC_W-1:0] best;
  logic [15:0]      best_val;
  logic             out_valid;
  logic [SEC_W-1:0] rd_idx;
  logic [15:0]      rd_val;
  logic             cnt_end;
  logic             out_free;
  logic             out_load;
  logic [2:0]       steer;

  // One read port into the minima, shared by update, scan and drain.
  assign rd_idx   = (state == ST_RUN) ? entry.sector : cnt;
  assign rd_val   = minima[rd_idx];
  assign cnt_end  = (cnt == SEC_W'(SECTORS - 1));
  assign out_free = !out_valid || pop;
  assign out_load = (state == ST_EMIT) && out_free;
  assign q_rd     = (state == ST_RUN) && !q_empty;
  assign empty    = !out_valid;
  assign steer    = 3'(32'(best) - 32'(SECTORS / 2));

  // Sequencer: update minima, scan for the best sector, then drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      cnt       <= '0;
      best      <= '0;
      best_val  <= '0;
      out_valid <= 1'b0;
      for (int s = 0; s < SECTORS; s++) begin
        minima[s] <= NO_RETURN;
      end
    end else begin
      // The output register fills on a drain step and empties when popped.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (!q_empty) begin
            if (entry.keep && (entry.range_mm < rd_val)) begin
              minima[entry.sector] <= entry.range_mm;
            end
            if (entry.last) begin
              state    <= ST_SCAN;
              cnt      <= '0;
              best     <= '0;
              best_val <= '0;
            end
          end
        end
        ST_SCAN: begin
          // Strictly greater keeps the lowest index on a tie.
          if (rd_val > best_val) begin
            best_val <= rd_val;
            best     <= cnt;
          end
          cnt <= cnt + 1'b1;
          if (cnt_end) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            cnt <= cnt + 1'b1;
            if (cnt_end) begin
              state <= ST_RUN;
              for (int s = 0; s < SECTORS; s++) begin
                minima[s] <= NO_RETURN;
              end
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      sector_index     <= 3'(cnt);
      sector_min_mm    <= rd_val;
      open_sector      <= 3'(best);
      steer_eighths_pi <= steer;
      last_of_run      <= cnt_end;
    end
  end

endmodule

/* dv/lidar_sector_min_binning_test.sv */
// ----------------------------------------------------------------------------
// lidar_sector_min_binning_test
// Self-checking bench for the lidar sector minimum binning block. A queue of
// scans feeds a clocked driver that predicts the eight sector results of each
// scan as its items are accepted; a clocked monitor pops results and checks
// them in order. Both sides idle at random, and the range window and angle
// registers change between phases while the block is idle.
// ----------------------------------------------------------------------------
module lidar_sector_min_binning_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsmb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PER_PHASE = 37;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  // One lidar sample as it waits to be sent.
  typedef struct packed {
    logic [15:0] range_mm;
    logic        not_finite;
    logic        end_of_scan;
  } sample_t;

  // One sector report of a closed scan.
  typedef struct packed {
    logic [2:0]  sector_index;
    logic [15:0] sector_min_mm;
    logic [2:0]  open_sector;
    logic [2:0]  steer_eighths_pi;
    logic        last_of_run;
  } sector_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [15:0] range_mm = '0;
  logic not_finite = 1'b0;
  logic end_of_scan = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] sector_index;
  logic [15:0] sector_min_mm;
  logic [2:0] open_sector;
  logic signed [2:0] steer_eighths_pi;
  logic last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Stimulus and expectation stores.
  sample_t        scan_queue[$];
  sector_report_t expected_reports[$];
  sample_t        on_port;

  // Predicted block state and registers.
  logic [15:0] sector_low[SECTORS];
  logic [15:0] beam_angle;
  logic [15:0] start_angle_reg;
  logic [15:0] angle_step_reg;
  logic [15:0] min_range_reg;
  logic [15:0] max_range_reg;
  logic [15:0] shifted_angle;
  logic [SEC_W-1:0] bin;
  logic [SEC_W-1:0] best_bin;
  logic [15:0] best_low;
  sector_report_t report;

  int tx_idle_pct = 32;
  int rx_idle_pct = 32;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;
  int cfg_acks = 0;
  int mismatches = 0;
  int cycle_count = 0;

  lidar_sector_min_binning i_dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .range_mm         (range_mm),
    .not_finite       (not_finite),
    .end_of_scan      (end_of_scan),
    .empty            (empty),
    .pop              (pop),
    .sector_index     (sector_index),
    .sector_min_mm    (sector_min_mm),
    .open_sector      (open_sector),
    .steer_eighths_pi (steer_eighths_pi),
    .last_of_run      (last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Register writes update the predicted configuration when accepted.
  always @(posedge clk) begin
    if (rst) begin
      start_angle_reg = RST_START_ANGLE;
      angle_step_reg  = RST_ANGLE_STEP;
      min_range_reg   = RST_MIN_RANGE;
      max_range_reg   = RST_MAX_RANGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ANGLE: begin
          start_angle_reg = cfg_data;
          beam_angle = cfg_data;
        end
        REG_ANGLE_STEP: begin
          angle_step_reg = cfg_data;
        end
        REG_MIN_RANGE: begin
          min_range_reg = cfg_data;
        end
        REG_MAX_RANGE: begin
          max_range_reg = cfg_data;
        end
        default: begin
        end
      endcase
      cfg_acks++;
    end
  end

  // Driver: bins each accepted item into the predicted minima, then offers the
  // next queued item unless it idles this cycle.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      beam_angle = RST_START_ANGLE;
      for (int s = 0; s < SECTORS; s++) sector_low[s] = NO_RETURN;
    end else begin
      if (push && !full) begin
        if (!on_port.not_finite && on_port.range_mm >= min_range_reg &&
            on_port.range_mm <= max_range_reg) begin
          shifted_angle = beam_angle + HALF_TURN;
          bin = shifted_angle[15 -: SEC_W];
          if (on_port.range_mm < sector_low[bin]) sector_low[bin] = on_port.range_mm;
        end
        beam_angle = beam_angle + angle_step_reg;

        // A closing item reports every sector and starts a fresh scan.
        if (on_port.end_of_scan) begin
          best_bin = '0;
          best_low = '0;
          for (int s = 0; s < SECTORS; s++) begin
            if (sector_low[s] > best_low) begin
              best_low = sector_low[s];
              best_bin = SEC_W'(s);
            end
          end
          for (int s = 0; s < SECTORS; s++) begin
            report.sector_index     = 3'(s);
            report.sector_min_mm    = sector_low[s];
            report.open_sector      = 3'(best_bin);
            report.steer_eighths_pi = 3'(best_bin) - 3'(SECTORS / 2);
            report.last_of_run      = (s == SECTORS - 1);
            expected_reports.insert(expected_reports.size(), report);
            sector_low[s] = NO_RETURN;
          end
          beam_angle = start_angle_reg;
        end
      end

      // The port is free once its item is taken or nothing was offered.
      if (!push || !full) begin
        if (scan_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          on_port = scan_queue.pop_front();
          push <= 1'b1;
          range_mm <= on_port.range_mm;
          not_finite <= on_port.not_finite;
          end_of_scan <= on_port.end_of_scan;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each popped result against the oldest expectation and
  // paces pop with random idling and requested long holds.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        report.sector_index     = sector_index;
        report.sector_min_mm    = sector_min_mm;
        report.open_sector      = open_sector;
        report.steer_eighths_pi = steer_eighths_pi;
        report.last_of_run      = last_of_run;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: sector %0d min %0d best %0d steer %0d last %0d",
                     sector_index, sector_min_mm, open_sector, steer_eighths_pi,
                     last_of_run);
        end else if (report != expected_reports[0]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected sector %0d min %0d best %0d steer %0d last %0d, ",
                      "got sector %0d min %0d best %0d steer %0d last %0d"},
                     expected_reports[0].sector_index, expected_reports[0].sector_min_mm,
                     expected_reports[0].open_sector,
                     $signed(expected_reports[0].steer_eighths_pi),
                     expected_reports[0].last_of_run, sector_index, sector_min_mm,
                     open_sector, steer_eighths_pi, last_of_run);
          void'(expected_reports.pop_front());
        end else begin
          void'(expected_reports.pop_front());
        end
      end

      if (hold_asked != hold_given) begin
        hold_left = HOLD_CYCLES;
        hold_given++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic add_sample(input logic [15:0] rng, input logic bad, input logic last);
    sample_t item;
    item.range_mm    = rng;
    item.not_finite  = bad;
    item.end_of_scan = last;
    scan_queue.insert(scan_queue.size(), item);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    int target;
    target = cfg_acks + 1;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    wait (cfg_acks == target);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_window(input logic [15:0] start, input logic [15:0] step,
                                input logic [15:0] lo, input logic [15:0] hi);
    write_reg(REG_START_ANGLE, start);
    write_reg(REG_ANGLE_STEP, step);
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_MAX_RANGE, hi);
  endtask

  // Waits until every queued item is taken and every report has come, then
  // lets the block settle so no closing item is still in flight. The check
  // runs at the falling edge, where the driver's updates have all landed.
  task automatic wait_drained();
    while (scan_queue.size() != 0 || push || expected_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Ranges cluster on the window edges, with full-width noise mixed in.
  function automatic logic [15:0] pick_range(input logic [15:0] lo, input logic [15:0] hi);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return lo;
    if (roll < 20) return lo - 16'd1;
    if (roll < 32) return hi;
    if (roll < 40) return hi + 16'd1;
    if (roll < 55 || lo > hi) return 16'($urandom());
    return lo + 16'($urandom_range(0, int'(hi) - int'(lo)));
  endfunction

  // Queues whole scans of random content until about count items are queued.
  task automatic queue_scans(input int count, input logic [15:0] lo, input logic [15:0] hi);
    int queued;
    int len;
    queued = 0;
    while (queued < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
        add_sample(pick_range(lo, hi), $urandom_range(0, 9) == 0, i == len - 1);
      queued += len;
    end
  endtask

  initial begin
    logic [15:0] start;
    logic [15:0] step;
    logic [15:0] lo;
    logic [15:0] hi;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset window: both range edges, just outside them, a non-finite item,
    // then a scan whose only item is dropped so every sector reports no return.
    add_sample(16'd99, 1'b0, 1'b0);
    add_sample(16'd100, 1'b0, 1'b0);
    add_sample(16'd30000, 1'b0, 1'b0);
    add_sample(16'd30001, 1'b0, 1'b0);
    add_sample(16'd50, 1'b1, 1'b0);
    add_sample(16'd5000, 1'b0, 1'b1);
    add_sample(16'd0, 1'b0, 1'b1);
    wait_drained();

    // Eighth-turn steps that wrap past the half turn cover every sector; an
    // unused register index must be ignored. The second scan ties all at 0.
    program_window(16'h7000, 16'h2000, 16'd0, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h1234);
    add_sample(16'd0, 1'b0, 1'b0);
    add_sample(16'hFFFF, 1'b0, 1'b0);
    add_sample(16'd1, 1'b0, 1'b0);
    add_sample(16'd40000, 1'b0, 1'b0);
    add_sample(16'd0, 1'b1, 1'b0);
    add_sample(16'h5555, 1'b0, 1'b0);
    add_sample(16'hAAAA, 1'b0, 1'b0);
    add_sample(16'd32768, 1'b0, 1'b1);
    for (int i = 0; i < 8; i++) add_sample(16'd0, 1'b0, i == 7);
    wait_drained();

    // Inverted limits drop everything.
    program_window(16'h0000, 16'h2000, 16'd500, 16'd400);
    add_sample(16'd450, 1'b0, 1'b0);
    add_sample(16'd500, 1'b0, 1'b1);
    wait_drained();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 5; phase++) begin
      tx_idle_pct = 32;
      rx_idle_pct = 32;
      case (phase)
        0: begin
          start = 16'($urandom());
          step  = 16'($urandom());
          lo    = 16'($urandom_range(0, 3000));
          hi    = 16'($urandom_range(20000, 65535));
        end
        1: begin
          start = 16'h8000;
          step  = 16'h7FFF;
          lo    = 16'd0;
          hi    = 16'hFFFF;
        end
        2: begin
          start = 16'h7FFF;
          step  = 16'h8000;
          lo    = 16'($urandom());
          hi    = 16'($urandom());
        end
        3: begin
          start = 16'h0000;
          step  = 16'($urandom_range(6000, 10000));
          lo    = 16'($urandom());
          hi    = lo;
        end
        default: begin
          start = 16'($urandom());
          step  = -16'($urandom_range(1, 12000));
          lo    = 16'($urandom_range(0, 1000));
          hi    = 16'($urandom_range(1000, 65535));
        end
      endcase
      program_window(start, step, lo, hi);

      // Phase one stalls the receiver while the sender streams flat out, so
      // the block fills up; phase two runs with no idling at all.
      if (phase == 1) begin
        tx_idle_pct = 0;
        queue_scans(RANDOM_PER_PHASE, lo, hi);
        hold_asked++;
      end else begin
        if (phase == 2) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        queue_scans(RANDOM_PER_PHASE, lo, hi);
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
